>>> src/swq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SwiGLU Q15 pair package
// Shared constants, the stage load struct and the small arithmetic helpers
// used by the lane datapath.
// ----------------------------------------------------------------------------
package swq_pkg;

    localparam int SIG_LIMIT   = 2048;
    localparam int SIG_HALF    = 16384;
    localparam int SIG_MAX     = 32767;
    localparam int OFF_MUL_SL  = 13;
    localparam int OFF_MUL_LN  = 3;
    localparam int OFF_MOD     = 17;
    localparam int OFF_BIAS    = 8;
    localparam int NUM_STAGES  = 4;

    // One load strobe per pipeline stage.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } swq_load_t;

    // Clamp a 19-bit signed value to the signed 16-bit range.
    function automatic logic signed [15:0] sat16(input logic signed [18:0] x);
        logic signed [15:0] r;
        if (x > 19'sd32767) begin
            r = 16'sh7fff;
        end else if (x < -19'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = x[15:0];
        end
        return r;
    endfunction

    // Remainder modulo 17 of a 16-bit value. Since 256 is 1 mod 17 the two
    // bytes are folded first; since 16 is -1 mod 17 the nibbles then subtract.
    function automatic logic [4:0] mod17(input logic [15:0] x);
        logic [8:0] s;
        logic [5:0] t;
        s = {1'b0, x[15:8]} + {1'b0, x[7:0]};
        t = 6'(2 * OFF_MOD) + {2'b00, s[3:0]} - {1'b0, s[8:4]};
        if (t >= 6'(2 * OFF_MOD)) begin
            t = t - 6'(2 * OFF_MOD);
        end else if (t >= 6'(OFF_MOD)) begin
            t = t - 6'(OFF_MOD);
        end
        return t[4:0];
    endfunction

endpackage
`default_nettype wire

>>> src/swq_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SwiGLU lane datapath
// Four register stages for one lane: sigmoid and gate product, SiLU and up
// product, saturation and slice scale, offset and final saturation.
// ----------------------------------------------------------------------------
module swq_lane
    import swq_pkg::*;
(
    input  wire logic               aclk,
    input  wire swq_load_t          load,
    input  wire logic [7:0]         slice_number,
    input  wire logic               lane_odd,
    input  wire logic signed [15:0] up,
    input  wire logic signed [15:0] gate,
    input  wire logic [15:0]        pair_index,
    output logic signed [15:0]      result
);

    // Stage 1: piecewise linear sigmoid and gate times sigmoid.
    logic [15:0]        sig;
    logic signed [16:0] sig_lin;
    logic signed [32:0] prod1;
    logic signed [31:0] p1_reg, p1_next;
    logic signed [15:0] up1_reg;
    logic [4:0]         idx_mod_reg, idx_mod_next;

    always_comb begin
        sig_lin = 17'sd16384 + (17'(gate) <<< 3);
        if (gate <= -16'sd2048) begin
            sig = 16'd0;
        end else if (gate >= 16'sd2048) begin
            sig = 16'(SIG_MAX);
        end else begin
            sig = sig_lin[15:0];
        end
        prod1        = gate * $signed({1'b0, sig});
        p1_next      = $signed(prod1[31:0]);
        idx_mod_next = mod17(pair_index);
    end

    always_ff @(posedge aclk) begin
        if (load.s1) begin
            p1_reg      <= p1_next;
            up1_reg     <= up;
            idx_mod_reg <= idx_mod_next;
        end
    end

    // Stage 2: SiLU with truncation toward zero, then up times SiLU.
    logic signed [31:0] p1_adj;
    logic signed [16:0] silu;
    logic signed [32:0] p2_reg, p2_next;
    logic [15:0]        off_sum;
    logic [4:0]         off_mod;
    logic signed [5:0]  delta2_reg, delta2_next;

    always_comb begin
        p1_adj  = p1_reg + (p1_reg[31] ? 32'sd32767 : 32'sd0);
        silu    = p1_adj[31:15];
        p2_next = up1_reg * silu;
        // Lane number is 2*index + odd, so its residue follows from the index's.
        off_sum = 16'(slice_number) * 16'(OFF_MUL_SL)
                + 16'(idx_mod_reg) * 16'(2 * OFF_MUL_LN)
                + (lane_odd ? 16'(OFF_MUL_LN) : 16'd0);
        off_mod = mod17(off_sum);
        if (slice_number == 8'd0) begin
            delta2_next = 6'sd0;
        end else begin
            delta2_next = $signed({1'b0, off_mod}) - 6'sd8;
        end
    end

    always_ff @(posedge aclk) begin
        if (load.s2) begin
            p2_reg     <= p2_next;
            delta2_reg <= delta2_next;
        end
    end

    // Stage 3: divide by 16384, saturate, scale by (256 + slice).
    // With slice zero the scale is exactly 256 and the offset is zero.
    logic signed [32:0] p2_adj;
    logic signed [15:0] swiglu;
    logic signed [9:0]  scale;
    logic signed [25:0] p3_reg, p3_next;
    logic signed [5:0]  delta3_reg;

    always_comb begin
        p2_adj  = p2_reg + (p2_reg[32] ? 33'sd16383 : 33'sd0);
        swiglu  = sat16(p2_adj[32:14]);
        scale   = $signed({2'b01, slice_number});
        p3_next = swiglu * scale;
    end

    always_ff @(posedge aclk) begin
        if (load.s3) begin
            p3_reg     <= p3_next;
            delta3_reg <= delta2_reg;
        end
    end

    // Stage 4: divide by 256, add the offset, saturate.
    logic signed [25:0] p3_adj;
    logic signed [18:0] adj_sum;
    logic signed [15:0] result_reg, result_next;

    always_comb begin
        p3_adj      = p3_reg + (p3_reg[25] ? 26'sd255 : 26'sd0);
        adj_sum     = $signed(p3_adj[25:8]) + delta3_reg;
        result_next = sat16(adj_sum);
    end

    always_ff @(posedge aclk) begin
        if (load.s4) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
`default_nettype wire

>>> src/swiglu_q15_pair_with_slice_adjust_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SwiGLU Q15 pair core with slice adjustment
// Two lanes of piecewise linear SwiGLU with saturation, followed by an
// optional per-slice scale and lane-dependent offset.
// ----------------------------------------------------------------------------
// Four register stages lie between input acceptance and result valid; the
// first loads at the accepting edge, the output register is last.
// Throughput: one pair per cycle while m_ready holds; each stage holds one
// item and moves whenever the stage after it is empty or moving.
// Reset (aresetn low, synchronous): all stage valid bits clear and
// slice_number returns to 0.
// ----------------------------------------------------------------------------
module swiglu_q15_pair_with_slice_adjust_core
    import swq_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_slice_number,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_up_lane0,
    input  wire logic signed [15:0] s_up_lane1,
    input  wire logic signed [15:0] s_gate_lane0,
    input  wire logic signed [15:0] s_gate_lane1,
    input  wire logic [15:0]        s_pair_index,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_result_lane0,
    output logic signed [15:0]      m_result_lane1
);

    logic [7:0] slice_reg, slice_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        slice_next = (cfg_valid && cfg_ready) ? cfg_slice_number : slice_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_reg <= 8'd0;
        end else begin
            slice_reg <= slice_next;
        end
    end

    // Stage valid bits; index 0 is the first stage, the last is the output.
    logic [NUM_STAGES-1:0] vld_reg, vld_next;
    logic [NUM_STAGES-1:0] stg_ready;
    swq_load_t             load;

    always_comb begin
        stg_ready[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stg_ready[i] = !vld_reg[i] || stg_ready[i+1];
        end
        vld_next[0] = stg_ready[0] ? s_valid : vld_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            vld_next[i] = stg_ready[i] ? vld_reg[i-1] : vld_reg[i];
        end
        load.s1 = stg_ready[0];
        load.s2 = stg_ready[1];
        load.s3 = stg_ready[2];
        load.s4 = stg_ready[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = stg_ready[0];
    assign m_valid = vld_reg[NUM_STAGES-1];

    swq_lane u_lane0 (
        .aclk         (aclk),
        .load         (load),
        .slice_number (slice_reg),
        .lane_odd     (1'b0),
        .up           (s_up_lane0),
        .gate         (s_gate_lane0),
        .pair_index   (s_pair_index),
        .result       (m_result_lane0)
    );

    swq_lane u_lane1 (
        .aclk         (aclk),
        .load         (load),
        .slice_number (slice_reg),
        .lane_odd     (1'b1),
        .up           (s_up_lane1),
        .gate         (s_gate_lane1),
        .pair_index   (s_pair_index),
        .result       (m_result_lane1)
    );

    // An empty first stage must always take an item.
    a_accept_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[0] |-> s_ready)
        else $error("first stage empty but input not ready");

    // An accepted item occupies the first stage on the next cycle.
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted item lost at first stage");

    // A blocked item in the third stage is held, not dropped.
    a_stage3_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[2] && !stg_ready[3]) |=> vld_reg[2])
        else $error("stalled item dropped from third stage");

endmodule
`default_nettype wire

>>> bench/tb_swiglu_q15_pair_with_slice_adjust_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SwiGLU Q15 pair core testbench
// Sends pairs of up and gate values through the core under several slice
// settings. Each accepted item is predicted in the bench, and each result is
// compared lane by lane against the oldest prediction. Both sides idle at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_swiglu_q15_pair_with_slice_adjust_core;
    import swq_pkg::*;

    localparam int PIPE_DEPTH  = NUM_STAGES;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_CYCLES = 80;

    typedef struct {
        logic signed [15:0] up0;
        logic signed [15:0] up1;
        logic signed [15:0] gate0;
        logic signed [15:0] gate1;
        logic [15:0]        index;
    } swiglu_in_t;

    typedef struct {
        logic signed [15:0] lane0;
        logic signed [15:0] lane1;
    } swiglu_pair_t;

    logic               aclk             = 1'b0;
    logic               aresetn          = 1'b0;
    logic               cfg_valid        = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_slice_number = '0;
    logic               s_valid          = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_up_lane0       = '0;
    logic signed [15:0] s_up_lane1       = '0;
    logic signed [15:0] s_gate_lane0     = '0;
    logic signed [15:0] s_gate_lane1     = '0;
    logic [15:0]        s_pair_index     = '0;
    logic               m_valid;
    logic               m_ready          = 1'b0;
    logic signed [15:0] m_result_lane0;
    logic signed [15:0] m_result_lane1;

    swiglu_in_t   pair_backlog[$];
    swiglu_pair_t swiglu_due[$];
    swiglu_in_t   offered;
    swiglu_pair_t want;
    logic [7:0]   slice_setting = '0;
    logic         steady        = 1'b0;
    logic         hold_armed    = 1'b1;
    int           hold_left     = 0;
    int           pairs_queued  = 0;
    int           pairs_taken   = 0;
    int           fail_count    = 0;
    int           stall_cycles  = 0;

    swiglu_q15_pair_with_slice_adjust_core DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_slice_number (cfg_slice_number),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_up_lane0       (s_up_lane0),
        .s_up_lane1       (s_up_lane1),
        .s_gate_lane0     (s_gate_lane0),
        .s_gate_lane1     (s_gate_lane1),
        .s_pair_index     (s_pair_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_lane0   (m_result_lane0),
        .m_result_lane1   (m_result_lane1)
    );

    always #10 aclk = ~aclk;

    function automatic longint clamp_q15(input longint v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    // Piecewise linear sigmoid, then gate * sigmoid / 2^15 and up * silu / 2^14.
    // SystemVerilog signed division truncates toward zero, as required.
    function automatic longint lane_silu_product(input logic signed [15:0] up,
                                                 input logic signed [15:0] gate);
        longint g;
        longint sig;
        longint silu;
        g = gate;
        if (g <= -SIG_LIMIT) begin
            sig = 0;
        end else if (g >= SIG_LIMIT) begin
            sig = SIG_MAX;
        end else begin
            sig = SIG_HALF + 8 * g;
        end
        silu = (g * sig) / 32768;
        return clamp_q15((longint'(up) * silu) / 16384);
    endfunction

    function automatic longint apply_slice(input longint v, input logic [7:0] slice,
                                           input longint lane);
        longint scale;
        longint delta;
        if (slice == 8'd0) begin
            return v;
        end
        scale = 256 + longint'(slice);
        delta = (longint'(slice) * OFF_MUL_SL + lane * OFF_MUL_LN) % OFF_MOD - OFF_BIAS;
        return clamp_q15((v * scale) / 256 + delta);
    endfunction

    function automatic swiglu_pair_t predict_swiglu_pair(input swiglu_in_t it,
                                                         input logic [7:0] slice);
        swiglu_pair_t r;
        longint lane;
        lane = 2 * longint'(it.index);
        r.lane0 = 16'(apply_slice(lane_silu_product(it.up0, it.gate0), slice, lane));
        r.lane1 = 16'(apply_slice(lane_silu_product(it.up1, it.gate1), slice, lane + 1));
        return r;
    endfunction

    function automatic logic signed [15:0] pick_gate();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(4)) - 2050);
            3: return 16'(int'($urandom_range(4)) + 2046);
            4, 5, 6: return 16'(int'($urandom_range(4200)) - 2100);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_up();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_index();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic enqueue_pair(input logic signed [15:0] up0, input logic signed [15:0] up1,
                                input logic signed [15:0] g0, input logic signed [15:0] g1,
                                input logic [15:0] idx);
        swiglu_in_t it;
        it.up0   = up0;
        it.up1   = up1;
        it.gate0 = g0;
        it.gate1 = g1;
        it.index = idx;
        pair_backlog.push_back(it);
        pairs_queued++;
    endtask

    task automatic enqueue_random();
        enqueue_pair(pick_up(), pick_up(), pick_gate(), pick_gate(), pick_index());
    endtask

    // Returns once every queued item has been taken and every result has come
    // back, then waits so that the core is fully idle.
    task automatic wait_drained();
        while (pairs_taken != pairs_queued || swiglu_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (PIPE_DEPTH) @(posedge aclk);
    endtask

    task automatic write_slice(input logic [7:0] value);
        @(posedge aclk);
        cfg_slice_number <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        slice_setting = value;
    endtask

    // Sender: offers the next backlog item whenever the channel is free.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                swiglu_due.push_back(predict_swiglu_pair(offered, slice_setting));
                pairs_taken <= pairs_taken + 1;
            end
            if (!s_valid || s_ready) begin
                if (pair_backlog.size() != 0 && (steady || $urandom_range(99) >= 19)) begin
                    offered = pair_backlog.pop_front();
                    s_up_lane0   <= offered.up0;
                    s_up_lane1   <= offered.up1;
                    s_gate_lane0 <= offered.gate0;
                    s_gate_lane1 <= offered.gate1;
                    s_pair_index <= offered.index;
                    s_valid      <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so the core backs up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_armed && pairs_taken >= HOLD_AT) begin
            hold_armed <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 19);
        end
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (swiglu_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual lane0=%0d lane1=%0d",
                         $time, m_result_lane0, m_result_lane1);
                fail_count++;
            end else begin
                want = swiglu_due.pop_front();
                if (m_result_lane0 !== want.lane0) begin
                    $display("%0t: result_lane0 mismatch, expected %0d, actual %0d",
                             $time, want.lane0, m_result_lane0);
                    fail_count++;
                end
                if (m_result_lane1 !== want.lane1) begin
                    $display("%0t: result_lane1 mismatch, expected %0d, actual %0d",
                             $time, want.lane1, m_result_lane1);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int n;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Slice zero from reset: sigmoid thresholds, saturation, index extremes.
        enqueue_pair(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0000);
        enqueue_pair(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff);
        enqueue_pair(-16'sd32768, -16'sd32768, 16'sh7fff, 16'sh7fff, 16'h0000);
        enqueue_pair(16'sh7fff, -16'sd32768, -16'sd32768, -16'sd32768, 16'h8000);
        enqueue_pair(16'sh7fff, 16'sh7fff, -16'sd2049, -16'sd2048, 16'h0001);
        enqueue_pair(16'sh7fff, 16'sh7fff, -16'sd2047, -16'sd1, 16'h7fff);
        enqueue_pair(16'sh7fff, -16'sd32768, 16'sd1, 16'sd2047, 16'h1234);
        enqueue_pair(-16'sd32768, 16'sh7fff, 16'sd2048, 16'sd2049, 16'hfffe);
        enqueue_pair(16'sd1, -16'sd1, 16'sd2047, 16'sd2047, 16'h00ff);
        enqueue_pair(-16'sd1, 16'sd1, -16'sd2047, -16'sd2047, 16'hff00);
        enqueue_pair(16'sd16384, -16'sd16384, 16'sd1024, -16'sd1024, 16'h5555);
        enqueue_pair(16'sh5555, -16'sh5556, 16'sd4096, 16'sd512, 16'haaaa);
        enqueue_pair(16'sd100, 16'sd200, 16'sd3, -16'sd3, 16'h0002);
        enqueue_pair(-16'sd32768, -16'sd32768, -16'sd2047, 16'sd2047, 16'hffff);

        // Phases: slice 255, then one, zero at full rate, then random.
        for (int p = 0; p < 6; p++) begin
            wait_drained();
            case (p)
                0: write_slice(8'd255);
                1: write_slice(8'd1);
                2: write_slice(8'd0);
                default: write_slice(8'($urandom_range(254, 2)));
            endcase
            steady <= (p == 2);
            n = (p < 3) ? 120 : 110;
            for (int k = 0; k < n; k++) begin
                enqueue_random();
            end
        end
        wait_drained();
        repeat (2 * PIPE_DEPTH) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
